/* rtl/core/epr_pkg.sv */
`default_nettype none

package epr_pkg;

  localparam int NUM_CH          = 8;
  localparam int MAX_CHANNELS    = 8;
  localparam int CH_LIMIT        = (MAX_CHANNELS < NUM_CH) ? MAX_CHANNELS : NUM_CH;
  localparam int CH_W            = $clog2(NUM_CH);
  localparam int CNT_W           = 4;
  localparam int SINE_TABLE_SIZE = 256;
  localparam int TBL_BITS        = $clog2(SINE_TABLE_SIZE);
  localparam int FRAC_SH         = 16 - TBL_BITS;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [15:0] sample_t;
  typedef logic [15:0] sine_tab_t [SINE_TABLE_SIZE+1];

  // position stage result
  typedef struct {
    sample_t           samples [NUM_CH];
    logic [15:0]       frac;
    logic [CH_W-1:0]   offset;
    logic [CNT_W-1:0]  cnt;
  } pos_t;

  // gain stage result
  typedef struct {
    sample_t           samples [NUM_CH];
    logic [CH_W-1:0]   offset;
    logic [CNT_W-1:0]  cnt;
    sample_t           g_cos;
    sample_t           g_sin;
  } gain_t;

  // quarter-wave sine in q1.15, taylor series through x^13 in q30
  function automatic sine_tab_t build_sine();
    sine_tab_t         tab;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            sum;
    longint            r;
    for (int k = 0; k <= SINE_TABLE_SIZE; k++) begin
      x    = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_SIZE);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = (sum + 16384) >>> 15;
      if (r > 32767) begin
        r = 32767;
      end
      tab[k] = 16'(r);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

`default_nettype wire

/* rtl/core/epr_ifs.sv */
`default_nettype none

interface epr_in_if;
  import epr_pkg::*;
  logic              valid;
  logic              ready;
  sample_t           in_sample_0;
  sample_t           in_sample_1;
  sample_t           in_sample_2;
  sample_t           in_sample_3;
  sample_t           in_sample_4;
  sample_t           in_sample_5;
  sample_t           in_sample_6;
  sample_t           in_sample_7;
  logic signed [17:0] rotation;

  modport source (output valid, in_sample_0, in_sample_1, in_sample_2, in_sample_3,
                  in_sample_4, in_sample_5, in_sample_6, in_sample_7, rotation,
                  input ready);
  modport sink (input valid, in_sample_0, in_sample_1, in_sample_2, in_sample_3,
                in_sample_4, in_sample_5, in_sample_6, in_sample_7, rotation,
                output ready);
endinterface

interface epr_out_if;
  import epr_pkg::*;
  logic    valid;
  logic    ready;
  sample_t out_sample_0;
  sample_t out_sample_1;
  sample_t out_sample_2;
  sample_t out_sample_3;
  sample_t out_sample_4;
  sample_t out_sample_5;
  sample_t out_sample_6;
  sample_t out_sample_7;

  modport source (output valid, out_sample_0, out_sample_1, out_sample_2, out_sample_3,
                  out_sample_4, out_sample_5, out_sample_6, out_sample_7,
                  input ready);
  modport sink (input valid, out_sample_0, out_sample_1, out_sample_2, out_sample_3,
                out_sample_4, out_sample_5, out_sample_6, out_sample_7,
                output ready);
endinterface

interface epr_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] channel_count;

  modport source (output valid, channel_count, input ready);
  modport sink (input valid, channel_count, output ready);
endinterface

`default_nettype wire

/* rtl/core/epr_pos.sv */
`default_nettype none

module epr_pos (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [3:0]              channel_count,
  epr_in_if.sink                  in_chan,
  output epr_pkg::pos_t           pos,
  output logic                    pos_valid,
  input  logic                    pos_ready
);
  import epr_pkg::*;

  logic               valid_r;
  pos_t               pos_r;
  pos_t               pos_nxt;
  logic [CNT_W-1:0]   cnt;
  logic               rot_in_range;
  logic signed [22:0] idx_mul;
  logic signed [22:0] idx_s;
  logic [18:0]        idx_u;

  assign in_chan.ready = !valid_r || pos_ready;

  always_comb begin
    if (channel_count == '0) begin
      cnt = CNT_W'(1);
    end else if (channel_count > CNT_W'(CH_LIMIT)) begin
      cnt = CNT_W'(CH_LIMIT);
    end else begin
      cnt = channel_count;
    end
  end

  // a full turn or more in either direction means position zero
  assign rot_in_range = (in_chan.rotation < 18'sd65536) && (in_chan.rotation > -18'sd65536);
  assign idx_mul = 23'(in_chan.rotation) * 23'(signed'({1'b0, cnt}));

  always_comb begin
    idx_s = rot_in_range ? idx_mul : '0;
    if (idx_s < 0) begin
      idx_s = idx_s + signed'(23'({cnt, 16'h0000}));
    end
    idx_u = idx_s[18:0];
  end

  always_comb begin
    pos_nxt.samples[0] = in_chan.in_sample_0;
    pos_nxt.samples[1] = in_chan.in_sample_1;
    pos_nxt.samples[2] = in_chan.in_sample_2;
    pos_nxt.samples[3] = in_chan.in_sample_3;
    pos_nxt.samples[4] = in_chan.in_sample_4;
    pos_nxt.samples[5] = in_chan.in_sample_5;
    pos_nxt.samples[6] = in_chan.in_sample_6;
    pos_nxt.samples[7] = in_chan.in_sample_7;
    pos_nxt.frac       = idx_u[15:0];
    // wrapped index stays below count turns, so its integer part is the offset
    pos_nxt.offset     = idx_u[16+CH_W-1:16];
    pos_nxt.cnt        = cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      pos_r <= pos_nxt;
    end
  end

  assign pos       = pos_r;
  assign pos_valid = valid_r;

endmodule

`default_nettype wire

/* rtl/core/epr_gain.sv */
`default_nettype none

module epr_gain (
  input  logic            clk,
  input  logic            rst_n,
  input  epr_pkg::pos_t   pos,
  input  logic            pos_valid,
  output logic            pos_ready,
  output epr_pkg::gain_t  gain,
  output logic            gain_valid,
  input  logic            gain_ready
);
  import epr_pkg::*;

  localparam int PW = 18 + FRAC_SH;

  // index 0 is the cos phase, index 1 the sin phase
  logic [16:0]          ph       [2];
  logic [TBL_BITS:0]    k        [2];
  logic [15:0]          lo_nxt   [2];
  logic signed [16:0]   diff_nxt [2];
  logic [FRAC_SH-1:0]   fl_nxt   [2];

  logic                 a_valid_r;
  pos_t                 a_pos_r;
  logic [15:0]          lo_r     [2];
  logic signed [16:0]   diff_r   [2];
  logic [FRAC_SH-1:0]   fl_r     [2];

  logic signed [PW-1:0] prod     [2];
  logic signed [PW-1:0] gsum     [2];
  gain_t                gain_nxt;
  gain_t                gain_r;
  logic                 b_valid_r;
  logic                 en_a;
  logic                 en_b;

  assign en_b      = !b_valid_r || gain_ready;
  assign en_a      = !a_valid_r || en_b;
  assign pos_ready = en_a;

  always_comb begin
    ph[0] = 17'h10000 - {1'b0, pos.frac};
    ph[1] = {1'b0, pos.frac};
    for (int i = 0; i < 2; i++) begin
      k[i]      = ph[i][16:FRAC_SH];
      fl_nxt[i] = ph[i][FRAC_SH-1:0];
      if (k[i][TBL_BITS]) begin
        // quarter turn reached: last entry, no interpolation
        lo_nxt[i]   = SINE_TAB[SINE_TABLE_SIZE];
        diff_nxt[i] = '0;
      end else begin
        lo_nxt[i]   = SINE_TAB[k[i]];
        diff_nxt[i] = signed'({1'b0, SINE_TAB[k[i] + 1'b1]}) - signed'({1'b0, SINE_TAB[k[i]]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en_a) begin
      a_valid_r <= pos_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && pos_valid) begin
      a_pos_r <= pos;
      lo_r    <= lo_nxt;
      diff_r  <= diff_nxt;
      fl_r    <= fl_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      prod[i] = diff_r[i] * signed'({1'b0, fl_r[i]});
      gsum[i] = PW'(signed'({1'b0, lo_r[i]})) + (prod[i] >>> FRAC_SH);
    end
    gain_nxt.samples = a_pos_r.samples;
    gain_nxt.offset  = a_pos_r.offset;
    gain_nxt.cnt     = a_pos_r.cnt;
    gain_nxt.g_cos   = gsum[0][15:0];
    gain_nxt.g_sin   = gsum[1][15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en_b) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && a_valid_r) begin
      gain_r <= gain_nxt;
    end
  end

  assign gain       = gain_r;
  assign gain_valid = b_valid_r;

endmodule

`default_nettype wire

/* rtl/core/epr_mix.sv */
`default_nettype none

module epr_mix (
  input  logic            clk,
  input  logic            rst_n,
  input  epr_pkg::gain_t  gain,
  input  logic            gain_valid,
  output logic            gain_ready,
  epr_out_if.source       out_chan
);
  import epr_pkg::*;

  logic signed [CH_W+1:0] d_cos   [NUM_CH];
  logic signed [CH_W+1:0] d_sin   [NUM_CH];
  logic signed [31:0]     pc_nxt  [NUM_CH];
  logic signed [31:0]     ps_nxt  [NUM_CH];

  logic                   c_valid_r;
  logic signed [31:0]     pc_r    [NUM_CH];
  logic signed [31:0]     ps_r    [NUM_CH];
  logic [CNT_W-1:0]       cnt_r;

  logic signed [32:0]     acc     [NUM_CH];
  logic signed [17:0]     rnd     [NUM_CH];
  sample_t                out_nxt [NUM_CH];
  sample_t                out_r   [NUM_CH];
  logic                   out_valid_r;
  logic                   en_c;
  logic                   en_d;

  assign en_d       = !out_valid_r || out_chan.ready;
  assign en_c       = !c_valid_r || en_d;
  assign gain_ready = en_c;

  // output c takes cos from input c-offset and sin from input c-offset-1, modulo count
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      d_cos[c] = (CH_W+2)'(c) - signed'((CH_W+2)'(gain.offset));
      if (d_cos[c] < 0) begin
        d_cos[c] = d_cos[c] + signed'((CH_W+2)'(gain.cnt));
      end
      d_sin[c] = d_cos[c] - (CH_W+2)'(1);
      if (d_sin[c] < 0) begin
        d_sin[c] = d_sin[c] + signed'((CH_W+2)'(gain.cnt));
      end
      pc_nxt[c] = gain.g_cos * gain.samples[d_cos[c][CH_W-1:0]];
      ps_nxt[c] = gain.g_sin * gain.samples[d_sin[c][CH_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (en_c) begin
      c_valid_r <= gain_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c && gain_valid) begin
      pc_r  <= pc_nxt;
      ps_r  <= ps_nxt;
      cnt_r <= gain.cnt;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      acc[c] = 33'(pc_r[c]) + 33'(ps_r[c]) + 33'sd16384;
      rnd[c] = 18'(acc[c] >>> 15);
      if (CNT_W'(c) >= cnt_r) begin
        out_nxt[c] = '0;
      end else if (rnd[c] > 18'sd32767) begin
        out_nxt[c] = 16'sh7fff;
      end else if (rnd[c] < -18'sd32768) begin
        out_nxt[c] = 16'sh8000;
      end else begin
        out_nxt[c] = rnd[c][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_d) begin
      out_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d && c_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.out_sample_0 = out_r[0];
  assign out_chan.out_sample_1 = out_r[1];
  assign out_chan.out_sample_2 = out_r[2];
  assign out_chan.out_sample_3 = out_r[3];
  assign out_chan.out_sample_4 = out_r[4];
  assign out_chan.out_sample_5 = out_r[5];
  assign out_chan.out_sample_6 = out_r[6];
  assign out_chan.out_sample_7 = out_r[7];

endmodule

`default_nettype wire

/* rtl/core/multichannel_equal_power_rotator.sv */
// throughput: one frame per cycle while out_chan is ready; while it is held, frames
//   close up into empty stages, and in_chan stalls only once every stage is full
// stages: position scale, sine table read, gain interpolation multiply,
//   per-channel gain products, sum with rounding and saturation
// reset (rst_n low, synchronous): all stages empty, channel_count back to 1
`default_nettype none

module multichannel_equal_power_rotator (
  input  logic       clk,
  input  logic       rst_n,
  epr_in_if.sink     in_chan,
  epr_out_if.source  out_chan,
  epr_cfg_if.sink    cfg_chan
);
  import epr_pkg::*;

  logic [3:0] channel_count_r;
  pos_t       pos;
  logic       pos_valid;
  logic       pos_ready;
  gain_t      gain;
  logic       gain_valid;
  logic       gain_ready;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_count_r <= 4'd1;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      channel_count_r <= cfg_chan.channel_count;
    end
  end

  epr_pos u_pos (
    .clk           (clk),
    .rst_n         (rst_n),
    .channel_count (channel_count_r),
    .in_chan       (in_chan),
    .pos           (pos),
    .pos_valid     (pos_valid),
    .pos_ready     (pos_ready)
  );

  epr_gain u_gain (
    .clk        (clk),
    .rst_n      (rst_n),
    .pos        (pos),
    .pos_valid  (pos_valid),
    .pos_ready  (pos_ready),
    .gain       (gain),
    .gain_valid (gain_valid),
    .gain_ready (gain_ready)
  );

  epr_mix u_mix (
    .clk        (clk),
    .rst_n      (rst_n),
    .gain       (gain),
    .gain_valid (gain_valid),
    .gain_ready (gain_ready),
    .out_chan   (out_chan)
  );

`ifndef ASSERT_OFF
  // input can only back up when every stage is full and the output is held
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (out_chan.valid && !out_chan.ready && pos_valid && gain_valid))
    else $error("input stalled without a full pipeline");

  a_reset_count: assert property (@(posedge clk)
    !rst_n |=> (channel_count_r == 4'd1))
    else $error("channel count not restored by reset");

  a_gain_sign: assert property (@(posedge clk) disable iff (!rst_n)
    gain_valid |-> (!gain.g_cos[15] && !gain.g_sin[15]))
    else $error("negative pan gain");
`endif

endmodule

`default_nettype wire

/* dv/epr_mix_checker.sv */
module epr_mix_checker (
  input  logic        clk,
  input  logic        rst_n,
  epr_in_if           in_mon,
  epr_out_if          out_mon,
  epr_cfg_if          cfg_mon,
  output int unsigned mismatch_count,
  output int unsigned outstanding,
  output int unsigned results_checked
);

  localparam int FIELDS = 8;
  localparam int TABLE_N = 256;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

  typedef logic [FIELDS-1:0][15:0] mix_frame_t;

  int          quarter_sine [TABLE_N+1];
  logic [3:0]  count_setting;
  mix_frame_t  expected_mix_q [$];
  mix_frame_t  in_frame;
  mix_frame_t  got_mix;
  mix_frame_t  want_mix;

  initial begin
    mismatch_count = 0;
    results_checked = 0;
    outstanding = 0;
    count_setting = 4'd1;
    build_quarter_sine();
  end

  // sin over a quarter turn in q1.15, taylor series through x^13 in q30
  function automatic void build_quarter_sine();
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint          rounded;
    for (int k = 0; k <= TABLE_N; k++) begin
      x = (longint'(k) * QUARTER_TURN_Q30) / TABLE_N;
      x2 = (x * x) >> 30;
      term = x;
      acc = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        term = (term * x2) >> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      rounded = (acc + 16384) >>> 15;
      if (rounded > 32767) begin
        rounded = 32767;
      end
      quarter_sine[k] = int'(rounded);
    end
  endfunction

  function automatic int ring_channels(logic [3:0] setting);
    if (setting == 4'd0) begin
      return 1;
    end
    if (setting > 4'd8) begin
      return 8;
    end
    return int'(setting);
  endfunction

  // phase p in 0..65536 where 65536 is a quarter turn
  function automatic longint pan_gain(longint p);
    longint q;
    longint k;
    longint f;
    longint lo;
    longint hi;
    q = p * TABLE_N;
    k = q >>> 16;
    f = q & 64'hFFFF;
    if (k >= TABLE_N) begin
      return longint'(quarter_sine[TABLE_N]);
    end
    lo = longint'(quarter_sine[k]);
    hi = longint'(quarter_sine[k + 1]);
    return (lo * 65536 + (hi - lo) * f) >>> 16;
  endfunction

  function automatic mix_frame_t predict_mix(mix_frame_t samples, logic signed [17:0] rot,
                                             logic [3:0] setting);
    longint     n;
    longint     r;
    longint     pos;
    longint     offset;
    longint     frac;
    longint     g_cos;
    longint     g_sin;
    longint     v;
    longint     acc [FIELDS];
    mix_frame_t mix;
    n = longint'(ring_channels(setting));
    r = longint'(rot);
    if (r >= 65536 || r <= -65536) begin
      pos = 0;
    end else begin
      pos = r * n;
    end
    if (pos < 0) begin
      pos = pos + n * 65536;
    end
    offset = (pos >>> 16) % n;
    frac = pos & 64'hFFFF;
    g_sin = pan_gain(frac);
    g_cos = pan_gain(65536 - frac);
    for (int j = 0; j < FIELDS; j++) begin
      acc[j] = 0;
    end
    for (int j = 0; j < n; j++) begin
      acc[(j + offset) % n] += g_cos * longint'($signed(samples[j]));
      acc[(j + offset + 1) % n] += g_sin * longint'($signed(samples[j]));
    end
    for (int j = 0; j < FIELDS; j++) begin
      v = 0;
      if (j < n) begin
        v = (acc[j] + 16384) >>> 15;
        if (v > 32767) begin
          v = 32767;
        end
        if (v < -32768) begin
          v = -32768;
        end
      end
      mix[j] = 16'(v);
    end
    return mix;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at result %0d: %s", results_checked, msg);
    mismatch_count = mismatch_count + 1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      count_setting = 4'd1;
      expected_mix_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        count_setting = cfg_mon.channel_count;
      end
      if (in_mon.valid && in_mon.ready) begin
        in_frame[0] = in_mon.in_sample_0;
        in_frame[1] = in_mon.in_sample_1;
        in_frame[2] = in_mon.in_sample_2;
        in_frame[3] = in_mon.in_sample_3;
        in_frame[4] = in_mon.in_sample_4;
        in_frame[5] = in_mon.in_sample_5;
        in_frame[6] = in_mon.in_sample_6;
        in_frame[7] = in_mon.in_sample_7;
        expected_mix_q.push_back(predict_mix(in_frame, in_mon.rotation, count_setting));
      end
      if (out_mon.valid && out_mon.ready) begin
        got_mix[0] = out_mon.out_sample_0;
        got_mix[1] = out_mon.out_sample_1;
        got_mix[2] = out_mon.out_sample_2;
        got_mix[3] = out_mon.out_sample_3;
        got_mix[4] = out_mon.out_sample_4;
        got_mix[5] = out_mon.out_sample_5;
        got_mix[6] = out_mon.out_sample_6;
        got_mix[7] = out_mon.out_sample_7;
        if (expected_mix_q.size() == 0) begin
          report_mismatch("output transaction with no frame outstanding");
        end else begin
          want_mix = expected_mix_q.pop_front();
          for (int j = 0; j < FIELDS; j++) begin
            if (got_mix[j] !== want_mix[j]) begin
              report_mismatch($sformatf("out_sample_%0d got %0d expected %0d", j,
                                        $signed(got_mix[j]), $signed(want_mix[j])));
            end
          end
        end
        results_checked <= results_checked + 1;
      end
      outstanding <= expected_mix_q.size();
    end
  end

endmodule

/* dv/tb_multichannel_equal_power_rotator.sv */
module tb_multichannel_equal_power_rotator;
  import epr_pkg::*;

  typedef sample_t frame_t [NUM_CH];

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int PIPE_LATENCY = 5;
  localparam int NUM_PHASES = 12;
  localparam int FRAMES_PER_PHASE = 150;
  localparam logic [3:0] PHASE_COUNTS [NUM_PHASES] =
    '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd9, 4'd8};
  localparam logic signed [17:0] EDGE_ROTATIONS [12] =
    '{18'sd0, 18'sd65535, -18'sd65535, 18'sd65536, -18'sd65536, -18'sd131072,
      18'sd131071, 18'sd8192, 18'sd4096, -18'sd1, 18'sd1, 18'sd32768};

  logic        clk;
  logic        rst_n;
  int unsigned cycle_count = 0;
  int unsigned frames_sent = 0;
  int unsigned settings_used = 0;
  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned results_checked;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int          ring;

  epr_in_if  in_if ();
  epr_out_if out_if ();
  epr_cfg_if cfg_if ();

  multichannel_equal_power_rotator uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  epr_mix_checker mix_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_if),
    .out_mon         (out_if),
    .cfg_mon         (cfg_if),
    .mismatch_count  (mismatch_count),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d frames still owed", cycle_count, outstanding);
      $display("tb_multichannel_equal_power_rotator NOT OK");
      $finish;
    end
  end

  // receiver back-pressure
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return sample_t'(int'($urandom_range(64)) - 32);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic frame_t pattern_frame(int kind);
    frame_t f;
    for (int j = 0; j < NUM_CH; j++) begin
      case (kind)
        0: f[j] = 16'sh7FFF;
        1: f[j] = 16'sh8000;
        2: f[j] = (j % 2 == 0) ? 16'sh7FFF : 16'sh8000;
        3: f[j] = sample_t'(j * 4000 - 14000);
        default: f[j] = pick_sample();
      endcase
    end
    return f;
  endfunction

  function automatic logic signed [17:0] pick_rotation(int n);
    int k;
    k = $urandom_range(2 * n) - n;
    case ($urandom_range(15))
      0: return 18'($urandom);
      1: return 18'(65536);
      2: return 18'(-65536);
      3: return 18'(-131072);
      4: return 18'(131071);
      5: return 18'(k * 65536 / n);
      6: return 18'(k * 65536 / n + 1);
      7: return 18'(k * 65536 / n - 1);
      default: return 18'(int'($urandom_range(131070)) - 65535);
    endcase
  endfunction

  task automatic send_frame(frame_t f, logic signed [17:0] rot);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.in_sample_0 <= f[0];
    in_if.in_sample_1 <= f[1];
    in_if.in_sample_2 <= f[2];
    in_if.in_sample_3 <= f[3];
    in_if.in_sample_4 <= f[4];
    in_if.in_sample_5 <= f[5];
    in_if.in_sample_6 <= f[6];
    in_if.in_sample_7 <= f[7];
    in_if.rotation <= rot;
    do @(posedge clk); while (!in_if.ready);
    frames_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_channel_count(logic [3:0] setting);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.channel_count <= setting;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    ring = (setting == 4'd0) ? 1 : (setting > 4'd8) ? 8 : int'(setting);
    settings_used++;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.in_sample_0 <= '0;
    in_if.in_sample_1 <= '0;
    in_if.in_sample_2 <= '0;
    in_if.in_sample_3 <= '0;
    in_if.in_sample_4 <= '0;
    in_if.in_sample_5 <= '0;
    in_if.in_sample_6 <= '0;
    in_if.in_sample_7 <= '0;
    in_if.rotation <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.channel_count <= '0;
    send_idle_pct = 0;
    stall_pct = 0;
    ring = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single channel from reset, upper inputs must be ignored
    send_frame(pattern_frame(3), 18'sd0);
    send_frame(pattern_frame(2), 18'sd32768);
    send_frame(pattern_frame(0), -18'sd131072);

    write_channel_count(4'd8);
    for (int i = 0; i < 12; i++) begin
      send_frame(pattern_frame(i % 4), EDGE_ROTATIONS[i]);
    end

    // zero count acts as one, over-limit count acts as eight
    write_channel_count(4'd0);
    send_frame(pattern_frame(3), 18'sd16384);
    send_frame(pattern_frame(1), -18'sd65535);
    write_channel_count(4'd15);
    send_frame(pattern_frame(0), 18'sd4096);
    send_frame(pattern_frame(1), 18'sd131071);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_channel_count(PHASE_COUNTS[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 55; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 55; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      for (int i = 0; i < FRAMES_PER_PHASE; i++) begin
        // full-scale frames now and then to push the sums into saturation
        if ($urandom_range(7) == 0) begin
          send_frame(pattern_frame($urandom_range(1)), pick_rotation(ring));
        end else begin
          send_frame(pattern_frame(4), pick_rotation(ring));
        end
      end
    end

    wait_drained();
    repeat (PIPE_LATENCY * 2) @(posedge clk);
    $display("%0d frames over %0d channel-count writes, zero and over-limit counts included",
             frames_sent, settings_used);
    $display("%0d mixed frames compared, %0d field mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_multichannel_equal_power_rotator OK");
    end else begin
      $display("tb_multichannel_equal_power_rotator NOT OK");
    end
    $finish;
  end

endmodule
